>>> design/conv3x3_wrap_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 wrap filter core
// Shared property forms; every use samples on clk and is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_WRAP_FILTER_CORE_ASSERT_SVH
`define CONV3X3_WRAP_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define C3WF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3wf assertion failed");

// next-cycle implication
`define C3WF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3wf assertion failed");

`endif

>>> design/c3wf_pkg.sv
// ----------------------------------------------------------------------------
// c3wf_pkg
// Widths, reset values and shared types of the 3x3 wrap filter core.
// ----------------------------------------------------------------------------
package c3wf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W       = 8;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int ROW_W       = HEIGHT_W + 1;
  localparam int MASK_W      = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int TAPS        = 9;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MASK_TOP     = 3'd2,
    REG_MASK_MIDDLE  = 3'd3,
    REG_MASK_BOTTOM  = 3'd4
  } cfg_reg_t;

  // both previous rows share one memory word: upper in the high byte
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_word_t       data;
  } line_wr_t;

endpackage

>>> design/c3wf_ram.sv
// ----------------------------------------------------------------------------
// c3wf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c3wf_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/c3wf_line_buf.sv
// ----------------------------------------------------------------------------
// c3wf_line_buf
// Two-row line store with a write-to-read bypass for a same-address access.
// ----------------------------------------------------------------------------
module c3wf_line_buf
  import c3wf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [COL_W-1:0] rd_addr,
  input  line_wr_t         wr,
  output line_word_t       rd_data
);

  line_word_t ram_q;
  logic       bypass;
  line_word_t bypass_data;

  c3wf_ram #(
    .DATA_W ($bits(line_word_t)),
    .DEPTH  (MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // a one-pixel-wide row reads back the column it has just written
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else begin
      bypass <= wr.en && (wr.addr == rd_addr);
    end
    bypass_data <= wr.data;
  end

  assign rd_data = bypass ? bypass_data : ram_q;

endmodule

>>> design/conv3x3_wrap_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_wrap_filter_core
// A result travels from the pixel that completes its neighbourhood through the
// input register, the product register and the output register.
// Throughput: one item per cycle unless out_stall holds the pipeline, set by the
// single line-store read port that is read ahead for the next column.
// Reset clears counters, window, valids and masks and loads the default geometry;
// the line store is not cleared.
// ----------------------------------------------------------------------------
`include "conv3x3_wrap_filter_core_assert.svh"

module conv3x3_wrap_filter_core
  import c3wf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [PIX_W-1:0]       in_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       out_pixel,
  output logic                   frame_last
);

  // configuration
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [MASK_W-1:0]   mask_top, mask_middle, mask_bottom;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  // frame state
  logic [COL_W-1:0]    in_column, in_column_next;
  logic [ROW_W-1:0]    in_row, in_row_next;
  logic [COL_W-1:0]    out_column, out_column_next;
  logic [HEIGHT_W-1:0] out_row, out_row_next;
  logic [PIX_W-1:0]    win [TAPS];
  logic [PIX_W-1:0]    win_next [TAPS];

  // pipeline
  logic             s1_valid, s1_func;
  logic [PIX_W-1:0] s1_pixel;
  logic             s2_valid, s2_last;
  logic [PIX_W-1:0] s2_prod [TAPS];
  logic             out_free, s2_free, proc, in_take;

  // step results
  logic             restart, skip, have, res_last;
  logic [PIX_W-1:0] prod [TAPS];
  line_wr_t         line_wr;
  line_word_t       line_rd;
  logic [COL_W-1:0] line_raddr;
  logic [PIX_W-1:0] sum;

  function automatic logic needs_restart(
    input logic [COL_W-1:0]    ic,
    input logic [ROW_W-1:0]    ir,
    input logic [COL_W-1:0]    oc,
    input logic [HEIGHT_W-1:0] orow,
    input logic [WIDTH_W-1:0]  w,
    input logic [HEIGHT_W-1:0] h
  );
    return ({1'b0, ic} >= w) || ({1'b0, oc} >= w) || (orow >= h) ||
           (ir > ({1'b0, h} + ROW_W'(1)));
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      mask_top     <= '0;
      mask_middle  <= '0;
      mask_bottom  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        REG_MASK_TOP:     mask_top     <= cfg_data;
        REG_MASK_MIDDLE:  mask_middle  <= cfg_data;
        REG_MASK_BOTTOM:  mask_bottom  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  end

  // handshake between stages
  assign out_free = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || out_free;
  assign proc     = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // one item's step: restart check, window shift, taps, counter advance
  always_comb begin
    logic [COL_W-1:0]    ic, oc;
    logic [ROW_W-1:0]    ir;
    logic [HEIGHT_W-1:0] orow;
    logic [PIX_W-1:0]    we [TAPS];
    logic [PIX_W-1:0]    nw [TAPS];
    logic [PIX_W-1:0]    pix, px, coef;
    logic [MASK_W-1:0]   mrow;
    logic [2*PIX_W-1:0]  full;
    logic                tap_on, col_last, row_last;
    logic [WIDTH_W-1:0]  ic_inc;

    restart = needs_restart(in_column, in_row, out_column, out_row, w_eff, h_eff);
    ic   = restart ? '0 : in_column;
    ir   = restart ? '0 : in_row;
    oc   = restart ? '0 : out_column;
    orow = restart ? '0 : out_row;
    for (int i = 0; i < TAPS; i++) begin
      we[i] = restart ? '0 : win[i];
    end

    skip = s1_func && (ir < {1'b0, h_eff});
    pix  = (ir < {1'b0, h_eff}) ? s1_pixel : '0;
    have = !skip && ((ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0)));

    for (int r = 0; r < 3; r++) begin
      nw[r*3]   = we[r*3+1];
      nw[r*3+1] = we[r*3+2];
    end
    nw[2] = line_rd.upper;
    nw[5] = line_rd.lower;
    nw[8] = pix;

    line_wr.en         = proc && !skip;
    line_wr.addr       = ic;
    line_wr.data.upper = line_rd.lower;
    line_wr.data.lower = pix;

    col_last = ({1'b0, oc} + WIDTH_W'(1)) >= w_eff;
    row_last = ({1'b0, orow} + ROW_W'(1)) >= {1'b0, h_eff};

    // at column zero the right column is the border of the previous row
    for (int r = 0; r < 3; r++) begin
      mrow = (r == 0) ? mask_top : ((r == 1) ? mask_middle : mask_bottom);
      for (int c = 0; c < 3; c++) begin
        tap_on = !((r == 0) && (orow == '0)) && !((r == 2) && row_last) &&
                 !((c == 0) && (oc == '0)) && !((c == 2) && col_last) &&
                 !((c == 2) && (ic == '0));
        px   = tap_on ? nw[r*3+c] : '0;
        coef = mrow[8*c +: 8];
        full = coef * px;
        prod[r*3+c] = full[PIX_W-1:0];
      end
    end

    res_last = have && row_last && col_last;

    // counters
    ic_inc = {1'b0, ic} + WIDTH_W'(1);
    if (ic_inc >= w_eff) begin
      in_column_next = '0;
      in_row_next    = ir + ROW_W'(1);
    end else begin
      in_column_next = ic_inc[COL_W-1:0];
      in_row_next    = ir;
    end
    out_column_next = oc;
    out_row_next    = orow;
    if (have) begin
      if (col_last) begin
        out_column_next = '0;
        out_row_next    = orow + HEIGHT_W'(1);
      end else begin
        out_column_next = oc + COL_W'(1);
      end
    end
    for (int i = 0; i < TAPS; i++) begin
      win_next[i] = nw[i];
    end

    if (skip) begin
      // drop the flush, keep only the restart
      in_column_next  = ic;
      in_row_next     = ir;
      out_column_next = oc;
      out_row_next    = orow;
      for (int i = 0; i < TAPS; i++) begin
        win_next[i] = we[i];
      end
    end else if (res_last) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
      for (int i = 0; i < TAPS; i++) begin
        win_next[i] = '0;
      end
    end

    if (!proc) begin
      in_column_next  = in_column;
      in_row_next     = in_row;
      out_column_next = out_column;
      out_row_next    = out_row;
      for (int i = 0; i < TAPS; i++) begin
        win_next[i] = win[i];
      end
    end

    // read ahead the column the next item will use
    line_raddr = needs_restart(in_column_next, in_row_next, out_column_next,
                               out_row_next, w_eff, h_eff) ? '0 : in_column_next;
  end

  c3wf_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (line_raddr),
    .wr      (line_wr),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_func  <= func;
      s1_pixel <= in_pixel;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (proc) begin
      s2_valid <= have;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
    if (proc) begin
      s2_last <= res_last;
      for (int i = 0; i < TAPS; i++) begin
        s2_prod[i] <= prod[i];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + s2_prod[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
    if (out_free && s2_valid) begin
      out_pixel  <= sum;
      frame_last <= s2_last;
    end
  end

  `C3WF_ASSERT_NOW(a_no_stall_when_empty, !s1_valid, !in_stall)
  `C3WF_ASSERT_NEXT(a_restart_after_last, proc && res_last,
    (in_column == '0) && (in_row == '0) && (out_column == '0) && (out_row == '0))
  `C3WF_ASSERT_NEXT(a_no_result_without_window, proc && !have, !s2_valid)
  `C3WF_ASSERT_NEXT(a_prod_hold, s2_valid && !out_free,
    s2_valid && $stable(s2_last) && $stable(s2_prod[4]))

endmodule
